@@ rtl/lkv_pkg.sv @@
// Package for the LRU key/value cache: field widths, operation codes,
// reset constants and the control struct of the shared compare unit.
// No dependencies.
package lkv_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// Capacity register after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	// Controls for one rank update in the sweep pass
	typedef struct packed {
		logic inc_all;   // age every entry other than the target
		logic is_target; // entry under update becomes most recent
	} lkv_rank_ctl_t;

endpackage

@@ rtl/lkv_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/lkv_cmp_unit.sv @@
// Shared compare unit of the LRU cache: key match and victim detection
// during the scan, rank ageing during the sweep. Depends on lkv_pkg.
module lkv_cmp_unit #(
	parameter int IW = 4
) (
	input  logic [lkv_pkg::KEY_W-1:0] key_rd,
	input  logic [lkv_pkg::KEY_W-1:0] key_req,
	input  logic [IW-1:0]             rank_rd,
	input  logic [IW-1:0]             pivot,
	input  logic [IW-1:0]             last_rank,
	input  lkv_pkg::lkv_rank_ctl_t    ctl,
	output logic                      key_eq,
	output logic                      is_last,
	output logic [IW-1:0]             rank_new
);

	import lkv_pkg::*;

	// Match the stored key and spot the least recent entry
	assign key_eq  = (key_rd == key_req);
	assign is_last = (rank_rd == last_rank);

	// Target goes to the front; entries ahead of it age by one, or every other entry when inc_all is set
	always_comb begin
		if (ctl.is_target) begin
			rank_new = '0;
		end else if (ctl.inc_all || (rank_rd < pivot)) begin
			rank_new = rank_rd + IW'(1);
		end else begin
			rank_new = rank_rd;
		end
	end

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
// LRU key/value cache, fully associative, ENTRIES entries, N = entries held.
// A request runs a key scan of N reads through the shared compare unit, then,
// but for a lookup miss, a rank sweep as read-modify-write on the rank RAM.
// One request at a time: in_stall is high from acceptance until the core is idle again.
// Reset clears the entry count, result valid and sets capacity to 16.
module lru_key_value_cache_core #(
	parameter int ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic signed [lkv_pkg::KEY_W-1:0]  key,
	input  logic signed [lkv_pkg::DATA_W-1:0] value,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic signed [lkv_pkg::DATA_W-1:0] read_value,
	// capacity register write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0]         cfg_data
);

	import lkv_pkg::*;

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SWEEP  = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]          state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       ptr_q;
	logic                pend_s1;
	logic [IW-1:0]       idx_s1;
	logic                op_q;
	logic [KEY_W-1:0]    key_q;
	logic [DATA_W-1:0]   val_q;
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic [IW-1:0]       hit_rank_q;
	logic [DATA_W-1:0]   hit_val_q;
	logic [IW-1:0]       vic_idx_q;
	logic [IW-1:0]       tgt_idx_q;
	logic                inc_all_q;
	logic                res_found_q;
	logic [DATA_W-1:0]   res_value_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [DATA_W-1:0]   out_value_q;

	logic                issue;
	logic [IW-1:0]       last_rank;
	logic                fill;
	logic [IW-1:0]       target;
	logic [KEY_W-1:0]    key_rd;
	logic [DATA_W-1:0]   val_rd;
	logic [IW-1:0]       rank_rd;
	logic                key_eq;
	logic                is_last;
	logic [IW-1:0]       rank_new;
	lkv_rank_ctl_t       rank_ctl;
	logic                key_we;
	logic                val_we;
	logic                rank_we;
	logic                load_out;

	// Request decode and shared scan pointer
	assign issue     = (ptr_q < cnt_q);
	assign last_rank = IW'(cnt_q - CW'(1));
	assign fill      = !hit_q && (op_q == OP_STORE)
	                   && ((cnt_q == '0) || (CMPW'(cnt_q) < CMPW'(cap_q)))
	                   && (cnt_q < CW'(ENTRIES));
	assign target    = hit_q ? hit_idx_q : (fill ? cnt_q[IW-1:0] : vic_idx_q);

	assign rank_ctl.inc_all   = inc_all_q;
	assign rank_ctl.is_target = (idx_s1 == tgt_idx_q);

	assign key_we  = (state_q == S_DECIDE) && (op_q == OP_STORE) && !hit_q;
	assign val_we  = (state_q == S_DECIDE) && (op_q == OP_STORE);
	assign rank_we = (state_q == S_SWEEP) && pend_s1;

	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid  = out_valid_q;
	assign found      = out_found_q;
	assign read_value = out_value_q;

	// Storage
	lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES), .AW(IW)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (target),
		.wdata (key_q),
		.raddr (ptr_q[IW-1:0]),
		.rdata (key_rd)
	);

	lkv_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES), .AW(IW)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (target),
		.wdata (val_q),
		.raddr (ptr_q[IW-1:0]),
		.rdata (val_rd)
	);

	lkv_ram #(.WIDTH(IW), .DEPTH(ENTRIES), .AW(IW)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_new),
		.raddr (ptr_q[IW-1:0]),
		.rdata (rank_rd)
	);

	// Shared compare unit
	lkv_cmp_unit #(.IW(IW)) u_cmp (
		.key_rd    (key_rd),
		.key_req   (key_q),
		.rank_rd   (rank_rd),
		.pivot     (hit_rank_q),
		.last_rank (last_rank),
		.ctl       (rank_ctl),
		.key_eq    (key_eq),
		.is_last   (is_last),
		.rank_new  (rank_new)
	);

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ptr_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ptr_q   <= '0;
						pend_s1 <= 1'b0;
						hit_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					pend_s1 <= issue;
					if (pend_s1 && key_eq && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!issue && !pend_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					ptr_q   <= '0;
					pend_s1 <= 1'b0;
					if (fill) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if ((op_q == OP_LOOKUP) && !hit_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					pend_s1 <= issue;
					if (!issue && !pend_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and scan results
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q  <= operation;
			key_q <= key;
			val_q <= value;
		end
		if (state_q == S_SCAN || state_q == S_SWEEP) begin
			idx_s1 <= ptr_q[IW-1:0];
		end
		if (state_q == S_SCAN && pend_s1) begin
			if (key_eq && !hit_q) begin
				hit_idx_q  <= idx_s1;
				hit_rank_q <= rank_rd;
				hit_val_q  <= val_rd;
			end
			if (is_last) begin
				vic_idx_q <= idx_s1;
			end
		end
		if (state_q == S_DECIDE) begin
			tgt_idx_q   <= target;
			inc_all_q   <= !hit_q;
			res_found_q <= hit_q;
			res_value_q <= ((op_q == OP_LOOKUP) && hit_q) ? hit_val_q : '0;
		end
	end

	// Result register: hold while stalled, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_found_q <= res_found_q;
			out_value_q <= res_value_q;
		end
	end

endmodule

@@ tb/tb_lru_key_value_cache_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lru_key_value_cache_core: a directed table and then random
// store/lookup traffic over several capacity settings, checked against a shadow LRU cache.
// Depends on lkv_pkg and the core RTL only.
module tb_lru_key_value_cache_core;
	import lkv_pkg::*;

	localparam int ENTRIES   = 16;
	localparam int LIMIT     = 600000;
	localparam int POOL_SIZE = 24;
	localparam int PHASES    = 12;
	localparam int PER_PHASE = 62;
	localparam int DIR_ROWS  = 20;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_value;
	} answer_t;

	typedef struct packed {
		logic              op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
		logic              typed;
		logic              exp_found;
		logic [DATA_W-1:0] exp_value;
	} dir_row_t;

	// Directed requests; typed rows carry their answer, the rest use the shadow cache
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_STORE,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
		'{OP_STORE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{OP_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{OP_STORE,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000},
		'{OP_STORE,  32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{OP_LOOKUP, 32'h7FFF_FFFE, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'h1234_5678, 32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_STORE,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_STORE,  32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'h5555_5555, 32'h0000_0000, 1'b1, 1'b1, 32'hAAAA_AAAA},
		'{OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 1'b1, 1'b1, 32'h5555_5555},
		'{OP_STORE,  32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
		'{OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
	};

	// Capacity per random phase: zero and above-range values, a lowering below the count
	localparam logic [CAP_W-1:0] PHASE_CAP [PHASES] = '{
		5'd0, 5'd1, 5'd2, 5'd31, 5'd3, 5'd16, 5'd17, 5'd5, 5'd1, 5'd16, 5'd9, 5'd4
	};

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     operation;
	logic signed [KEY_W-1:0]  key;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic                     found;
	logic signed [DATA_W-1:0] read_value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data;

	// Shadow copy of the cache contents
	logic [KEY_W-1:0]  shadow_key  [ENTRIES];
	logic [DATA_W-1:0] shadow_val  [ENTRIES];
	bit                shadow_used [ENTRIES];
	int                shadow_rank [ENTRIES];
	int                shadow_count;
	logic [CAP_W-1:0]  shadow_cap;

	answer_t          answer_q [$];
	answer_t          oldest;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               error_count;
	int               cycle_count;
	int               stall_left;
	bit               quiet;

	lru_key_value_cache_core #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.read_value (read_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Idle length: mostly none or short, now and then long; none in quiet phases
	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Make an entry most recent; entries more recent than it age by one
	function automatic void promote(int idx);
		int r;
		r = shadow_rank[idx];
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_used[i] && i != idx && shadow_rank[i] < r)
				shadow_rank[i]++;
		shadow_rank[idx] = 0;
	endfunction

	// Apply one request to the shadow cache and return its answer
	function automatic answer_t cache_access(logic op, logic [KEY_W-1:0] k,
			logic [DATA_W-1:0] v);
		answer_t a;
		int      hit;
		int      slot;
		int      victim;
		int      eff;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && shadow_used[i] && shadow_key[i] == k)
				hit = i;
		a.found      = (hit >= 0);
		a.read_value = '0;
		if (hit >= 0) begin
			if (op == OP_LOOKUP)
				a.read_value = shadow_val[hit];
			else
				shadow_val[hit] = v;
			promote(hit);
			return a;
		end
		if (op == OP_LOOKUP)
			return a;
		eff = (shadow_cap == 0) ? 1 : (shadow_cap > ENTRIES) ? ENTRIES : int'(shadow_cap);
		if (shadow_count < eff) begin
			// fill the lowest free entry, ageing every held one
			slot = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !shadow_used[i])
					slot = i;
			for (int i = 0; i < ENTRIES; i++)
				if (shadow_used[i])
					shadow_rank[i]++;
			shadow_used[slot] = 1'b1;
			shadow_key[slot]  = k;
			shadow_val[slot]  = v;
			shadow_rank[slot] = 0;
			shadow_count++;
		end else begin
			// replace the least recent entry
			victim = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (shadow_used[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
					victim = i;
			if (victim >= 0) begin
				shadow_key[victim] = k;
				shadow_val[victim] = v;
				promote(victim);
			end
		end
		return a;
	endfunction

	// Offer one request after a random gap and queue its answer once taken
	task automatic send_request(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v,
			logic typed, logic exp_found, logic [DATA_W-1:0] exp_value);
		int      gap;
		answer_t pred;
		gap = idle_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		key       = k;
		value     = v;
		in_valid  = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = cache_access(op, k, v);
		if (typed) begin
			pred.found      = exp_found;
			pred.read_value = exp_value;
		end
		answer_q.push_back(pred);
		@(negedge clk);
	endtask

	// Write the capacity register once the core has drained
	task automatic set_capacity(logic [CAP_W-1:0] c);
		in_valid = 1'b0;
		wait (answer_q.size() == 0);
		repeat (2 * ENTRIES + 8) @(negedge clk);
		cfg_data  = c;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_cap = c;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side back-pressure
	always @(negedge clk) begin
		int n;
		if (stall_left > 0) begin
			stall_left--;
			out_stall = 1'b1;
		end else begin
			n = idle_len();
			out_stall  = (n > 0);
			stall_left = (n > 0) ? n - 1 : 0;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected result found=%0b read_value=%h",
					$time, found, read_value);
				error_count++;
			end else begin
				oldest = answer_q.pop_front();
				if (found !== oldest.found) begin
					$display("%0t: found expected %0b got %0b", $time, oldest.found, found);
					error_count++;
				end
				if (read_value !== oldest.read_value) begin
					$display("%0t: read_value expected %h got %h",
						$time, oldest.read_value, read_value);
					error_count++;
				end
			end
		end
	end

	// Hold a watchdog over the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("** lru_key_value_cache_core: FAILED **");
			$finish;
		end
	end

	initial begin
		logic             op;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] last_key;
		int               r;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_LOOKUP;
		key          = '0;
		value        = '0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		error_count  = 0;
		cycle_count  = 0;
		stall_left   = 0;
		quiet        = 1'b0;
		shadow_count = 0;
		shadow_cap   = CAP_RESET;
		last_key     = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_used[i] = 1'b0;
			shadow_rank[i] = 0;
			shadow_key[i]  = '0;
			shadow_val[i]  = '0;
		end
		// keys reused often so that hits, refreshes and evictions occur
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'h7FFF_FFFF;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (int i = 0; i < DIR_ROWS; i++)
			send_request(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].value,
				DIRECTED[i].typed, DIRECTED[i].exp_found, DIRECTED[i].exp_value);

		// Random phases, one capacity each
		for (int p = 0; p < PHASES; p++) begin
			set_capacity(PHASE_CAP[p]);
			quiet = (p % 4 == 2);
			for (int n = 0; n < PER_PHASE; n++) begin
				r  = $urandom_range(0, 99);
				op = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
				if (r < 15)
					k = $urandom;
				else if (r < 35)
					k = last_key;
				else
					k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				last_key = k;
				send_request(op, k, $urandom, 1'b0, 1'b0, '0);
			end
		end
		in_valid = 1'b0;

		// Drain, then allow for any stray result
		wait (answer_q.size() == 0);
		repeat (2 * ENTRIES + 20) @(posedge clk);
		if (error_count == 0 && answer_q.size() == 0)
			$display("** lru_key_value_cache_core: PASSED **");
		else
			$display("** lru_key_value_cache_core: FAILED **");
		$finish;
	end

endmodule

@@ lru_key_value_cache_core.f @@
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_cmp_unit.sv
rtl/lru_key_value_cache_core.sv
tb/tb_lru_key_value_cache_core.sv
